FILE: rtl/ipv4dp_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dp_pkg
// Shared types, codes and helpers for the dotted-decimal IPv4 parser.
// ----------------------------------------------------------------------------
package ipv4dp_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [1:0] DOTS_FULL  = 2'd3;
    localparam int unsigned OCTET_MAX = 255;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ZERO  = 2'd1,
        CLS_DIGIT = 2'd2
    } char_class_t;

    typedef enum logic {
        MODE_CHAR = 1'b0,
        MODE_END  = 1'b1
    } item_mode_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
        logic        mask_ok;
        logic [5:0]  prefix_len;
    } out_item_t;

    typedef struct packed {
        char_class_t prev_class;
        logic [1:0]  dot_count;
        logic [7:0]  octet_value;
        logic [23:0] done_octets;
        logic        error_seen;
    } parse_state_t;

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

FILE: rtl/ipv4dp_parse_state.sv
// ----------------------------------------------------------------------------
// ipv4dp_parse_state
// Per-string parse state: octet accumulation, dot counting and sticky error.
// Cleared on every end transfer.
// ----------------------------------------------------------------------------
module ipv4dp_parse_state (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  ipv4dp_pkg::in_item_t      item,
    output ipv4dp_pkg::parse_state_t  state
);
    import ipv4dp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic [11:0]  octet_sum;
    logic [3:0]   digit;
    logic         is_digit;

    assign digit     = item.char_code[3:0] - CHAR_ZERO[3:0];
    assign is_digit  = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
    assign octet_sum = {1'b0, state_reg.octet_value, 3'b000}
                     + {3'b000, state_reg.octet_value, 1'b0}
                     + {8'h00, digit};

    always_comb begin
        state_next = state_reg;
        if (item.mode == MODE_END) begin
            state_next = '{CLS_NONE, 2'd0, 8'd0, 24'd0, 1'b0};
        end else if (!state_reg.error_seen) begin
            if (is_digit) begin
                if (state_reg.octet_value == 8'd0 && state_reg.prev_class == CLS_ZERO) begin
                    state_next.error_seen = 1'b1;
                end else if (octet_sum > 12'(OCTET_MAX)) begin
                    state_next.error_seen = 1'b1;
                end else begin
                    state_next.octet_value = octet_sum[7:0];
                    state_next.prev_class  = (item.char_code == CHAR_ZERO) ? CLS_ZERO
                                                                           : CLS_DIGIT;
                end
            end else if (item.char_code == CHAR_DOT) begin
                if (state_reg.prev_class == CLS_NONE || state_reg.dot_count == DOTS_FULL) begin
                    state_next.error_seen = 1'b1;
                end else begin
                    state_next.dot_count   = state_reg.dot_count + 2'd1;
                    state_next.done_octets = {state_reg.done_octets[15:0],
                                              state_reg.octet_value};
                    state_next.octet_value = 8'd0;
                    state_next.prev_class  = CLS_NONE;
                end
            end else begin
                state_next.error_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{CLS_NONE, 2'd0, 8'd0, 24'd0, 1'b0};
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: rtl/ipv4dp_result_gen.sv
// ----------------------------------------------------------------------------
// ipv4dp_result_gen
// Builds the result from the parse state: validity, address, netmask check
// and prefix length.
// ----------------------------------------------------------------------------
module ipv4dp_result_gen (
    input  ipv4dp_pkg::parse_state_t state,
    output ipv4dp_pkg::out_item_t    result
);
    import ipv4dp_pkg::*;

    logic        valid_str;
    logic [31:0] addr;
    logic [31:0] inv;
    logic [31:0] inv_inc;
    logic        contiguous;
    logic [5:0]  ones;

    assign valid_str  = !state.error_seen && (state.prev_class != CLS_NONE)
                     && (state.dot_count == DOTS_FULL);
    assign addr       = {state.done_octets, state.octet_value};
    assign inv        = ~addr;
    assign inv_inc    = inv + 32'd1;
    assign contiguous = (inv & inv_inc) == 32'd0;

    // contiguous mask: prefix length is the number of set bits
    assign ones = {2'b00, ones8(addr[31:24])} + {2'b00, ones8(addr[23:16])}
                + {2'b00, ones8(addr[15:8])}  + {2'b00, ones8(addr[7:0])};

    always_comb begin
        result = '0;
        if (valid_str) begin
            result.ok      = 1'b1;
            result.address = addr;
            if (contiguous) begin
                result.mask_ok    = 1'b1;
                result.prefix_len = ones;
            end
        end
    end

endmodule

FILE: rtl/ipv4_dotted_decimal_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_decimal_parser
// Streaming dotted-decimal IPv4 address parser with netmask check.
// ----------------------------------------------------------------------------
// Send the address text one character per transfer with mode 0, then one
// transfer with mode 1 to close the string. Only the closing transfer gives a
// result: ok, the 32-bit address (first octet in the top byte), and whether
// the address is a contiguous netmask together with its prefix length; all
// fields are zero when the string is not valid. The parser then starts afresh.
// One item is taken every cycle but while a closing transfer is held back:
// a character passes through an input register into the octet state
// register; the closing transfer passes through the input register into
// the result register, and m_valid rises when that register is loaded.
// Only a closing transfer can be held back, in the input register while the
// result register is full and m_ready is low; s_ready is low for that time.
module ipv4_dotted_decimal_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ipv4dp_pkg::in_item_t   s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ipv4dp_pkg::out_item_t  m_item
);
    import ipv4dp_pkg::*;

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    logic         step;
    logic         out_free;
    parse_state_t state;
    out_item_t    result;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && ((in_item_reg.mode == MODE_CHAR) || out_free);
    assign s_ready  = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    ipv4dp_parse_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .state   (state)
    );

    ipv4dp_result_gen u_result (
        .state  (state),
        .result (result)
    );

    // end transfer loads the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && in_item_reg.mode == MODE_END) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_item_reg.mode == MODE_END) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
